// ----- hdl/cd_toc_disc_id_core_defines.svh -----
// Assertion macros shared by the disc id block.
`ifndef CD_TOC_DISC_ID_CORE_DEFINES_SVH
`define CD_TOC_DISC_ID_CORE_DEFINES_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define CDID_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CDID_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define CDID_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define CDID_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- hdl/cdid_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cdid_pkg;

   localparam int FRAME_W = 24;
   localparam int SECS_W = 18;
   localparam int ID_W = 32;
   localparam int COUNT_W = 8;
   localparam int DSUM_TOTAL_W = 13;
   localparam int REM_W = 7;
   localparam int BCD_DIGITS = 6;
   localparam int DSUM_W = 6;
   localparam int MOD_W = 8;

   localparam int DEF_MAX_TRACKS = 99;

   localparam logic [FRAME_W-1:0] FRAME_BIAS = 24'd150;
   localparam logic [REM_W-1:0] FRAMES_PER_SEC = 7'd75;
   localparam logic [MOD_W:0] ID_MODULUS = 9'd255;

   typedef struct packed {
      logic [FRAME_W-1:0] start_block;
      logic               is_leadout;
   } req_type;

   typedef struct packed {
      logic [FRAME_W-1:0] frame_offset;
      logic [ID_W-1:0]    disc_id;
      logic [SECS_W-1:0]  leadout_secs;
      logic               id_valid;
   } rsp_type;

   // One quotient bit from the divider, most significant first.
   typedef struct packed {
      logic valid;
      logic q_bit;
      logic first;
      logic last;
   } qbit_type;

endpackage

`default_nettype wire

// ----- hdl/cdid_div75.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cdid_div75 (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [cdid_pkg::FRAME_W-1:0]  dividend,
   output cdid_pkg::qbit_type            qbit,
   output logic [cdid_pkg::SECS_W-1:0]   quotient
);
   import cdid_pkg::*;

   localparam int CNT_W = $clog2(FRAME_W);

   logic               busy_ff, busy_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [FRAME_W-1:0] num_ff, num_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [SECS_W-1:0]  quo_ff, quo_in;
   logic [REM_W:0]     trial;
   logic [REM_W:0]     diff;
   logic               ge;
   logic               last;

   assign trial = {rem_ff, num_ff[FRAME_W-1]};
   assign diff  = trial - {1'b0, FRAMES_PER_SEC};
   assign ge    = trial >= {1'b0, FRAMES_PER_SEC};
   assign last  = cnt_ff == CNT_W'(FRAME_W - 1);

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
         num_in = {num_ff[FRAME_W-2:0], 1'b0};
         quo_in = {quo_ff[SECS_W-2:0], ge};
         cnt_in = cnt_ff + CNT_W'(1);
         if (last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign qbit.valid = busy_ff;
   assign qbit.q_bit = ge;
   assign qbit.first = cnt_ff == '0;
   assign qbit.last  = last;
   assign quotient   = quo_ff;

endmodule

`default_nettype wire

// ----- hdl/cdid_digit_sum.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cdid_digit_sum (
   input  logic                          clock,
   input  logic                          reset,
   input  cdid_pkg::qbit_type            qbit,
   output logic                          done,
   output logic [cdid_pkg::DSUM_W-1:0]   digit_sum
);
   import cdid_pkg::*;

   localparam int BCD_W = 4 * BCD_DIGITS;
   localparam int CNT_W = $clog2(BCD_DIGITS);

   logic [BCD_W-1:0]  bcd_ff, bcd_in;
   logic [BCD_W-1:0]  adj;
   logic [DSUM_W-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              summing_ff, summing_in;
   logic              done_ff, done_in;

   always_comb begin
      logic [3:0] dig;
      for (int i = 0; i < BCD_DIGITS; i++) begin
         dig = bcd_ff[4*i +: 4];
         adj[4*i +: 4] = (dig >= 4'd5) ? dig + 4'd3 : dig;
      end
   end

   always_comb begin
      bcd_in     = bcd_ff;
      acc_in     = acc_ff;
      cnt_in     = cnt_ff;
      summing_in = summing_ff;
      done_in    = 1'b0;
      if (qbit.valid) begin
         if (qbit.first) begin
            bcd_in = {{(BCD_W-1){1'b0}}, qbit.q_bit};
         end else begin
            bcd_in = {adj[BCD_W-2:0], qbit.q_bit};
         end
         if (qbit.last) begin
            summing_in = 1'b1;
            cnt_in     = '0;
            acc_in     = '0;
         end
      end else if (summing_ff) begin
         acc_in = acc_ff + DSUM_W'(bcd_ff[BCD_W-1 -: 4]);
         bcd_in = {bcd_ff[BCD_W-5:0], 4'b0000};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(BCD_DIGITS - 1)) begin
            summing_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         summing_ff <= 1'b0;
         done_ff    <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         summing_ff <= summing_in;
         done_ff    <= done_in;
         cnt_ff     <= cnt_in;
      end
      bcd_ff <= bcd_in;
      acc_ff <= acc_in;
   end

   assign done      = done_ff;
   assign digit_sum = acc_ff;

endmodule

`default_nettype wire

// ----- hdl/cd_toc_disc_id_core.sv -----
// Disc id core: takes table-of-contents entries on the req_ channel, one track
// start address per transfer, closed by a transfer with is_leadout set. Each
// entry gives one transfer on the rsp_ channel with its frame offset; the
// lead-out transfer also carries the disc id and the total seconds, after which
// the running state is cleared for the next table.
// Each entry is worked in series: a bit-serial divider by 75 produces the start
// second one quotient bit per cycle, a shift-add-3 converter takes those bits into
// decimal as they arrive, and the six digits are then summed one per cycle. The
// result is registered once the sum is done, and req_ready returns in the same
// cycle, so a new entry is taken only after the last one is through.
// A finished result waits in the output register while the next entry is taken.
// If the receiver stalls, a completed entry is held until the output register
// frees, and req_ready stays low meanwhile.
// Reset clears the digit sum total, first track second, track count and all
// handshake state; no result is pending after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "cd_toc_disc_id_core_defines.svh"

module cd_toc_disc_id_core #(
   parameter int MAX_TRACKS = cdid_pkg::DEF_MAX_TRACKS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cdid_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cdid_pkg::rsp_type rsp_data
);
   import cdid_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CALC = 3'b010,
      ST_HOLD = 3'b100
   } state_type;

   state_type               state_ff, state_in;
   logic [FRAME_W-1:0]      frame_ff, frame_in;
   logic                    lead_ff, lead_in;
   logic [DSUM_TOTAL_W-1:0] dsum_ff, dsum_in;
   logic [SECS_W-1:0]       first_ff, first_in;
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic                    accept;
   logic                    slot_free;
   logic                    load_rsp;
   qbit_type                qbit;
   logic [SECS_W-1:0]       secs;
   logic                    sum_done;
   logic [DSUM_W-1:0]       digit_sum;
   logic [FRAME_W-1:0]      frame_next;
   logic [SECS_W-1:0]       first_sel;
   logic [ID_W-1:0]         play;
   logic [MOD_W:0]          fold;
   logic [MOD_W:0]          fold_sub;
   logic [MOD_W-1:0]        dsum_mod;
   logic [ID_W-1:0]         disc_id;
   logic                    track_ok;

   assign req_ready  = state_ff == ST_IDLE;
   assign accept     = req_valid && req_ready;
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign frame_next = req_data.start_block + FRAME_BIAS;

   cdid_div75 u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .dividend (frame_next),
      .qbit     (qbit),
      .quotient (secs)
   );

   cdid_digit_sum u_dsum (
      .clock     (clock),
      .reset     (reset),
      .qbit      (qbit),
      .done      (sum_done),
      .digit_sum (digit_sum)
   );

   always_comb begin
      state_in = state_ff;
      load_rsp = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            if (sum_done) begin
               if (slot_free) begin
                  load_rsp = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            if (slot_free) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The digit sum total is reduced mod 255 by folding the high bits onto the low byte.
   assign fold      = {{(MOD_W + 1 - (DSUM_TOTAL_W - MOD_W)){1'b0}}, dsum_ff[DSUM_TOTAL_W-1:MOD_W]}
                    + {1'b0, dsum_ff[MOD_W-1:0]};
   assign fold_sub  = fold - ID_MODULUS;
   assign dsum_mod  = (fold >= ID_MODULUS) ? fold_sub[MOD_W-1:0] : fold[MOD_W-1:0];

   assign first_sel = (count_ff == '0) ? secs : first_ff;
   assign play      = {{(ID_W-SECS_W){1'b0}}, secs} - {{(ID_W-SECS_W){1'b0}}, first_sel};
   assign disc_id   = {dsum_mod, {(ID_W-MOD_W){1'b0}}}
                    | {play[ID_W-COUNT_W-1:0], {COUNT_W{1'b0}}}
                    | {{(ID_W-COUNT_W){1'b0}}, count_ff};
   assign track_ok  = count_ff < COUNT_W'(MAX_TRACKS);

   always_comb begin
      frame_in     = frame_ff;
      lead_in      = lead_ff;
      dsum_in      = dsum_ff;
      first_in     = first_ff;
      count_in     = count_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         frame_in = frame_next;
         lead_in  = req_data.is_leadout;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_rsp) begin
         rsp_valid_in        = 1'b1;
         rsp_in.frame_offset = frame_ff;
         if (lead_ff) begin
            rsp_in.disc_id       = disc_id;
            rsp_in.leadout_secs  = secs;
            rsp_in.id_valid      = 1'b1;
            dsum_in              = '0;
            first_in             = '0;
            count_in             = '0;
         end else begin
            rsp_in.disc_id       = '0;
            rsp_in.leadout_secs  = '0;
            rsp_in.id_valid      = 1'b0;
            if (track_ok) begin
               if (count_ff == '0) begin
                  first_in = secs;
               end
               dsum_in  = dsum_ff + DSUM_TOTAL_W'(digit_sum);
               count_in = count_ff + COUNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dsum_ff      <= '0;
         first_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dsum_ff      <= dsum_in;
         first_ff     <= first_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      frame_ff <= frame_in;
      lead_ff  <= lead_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `CDID_ASSERT_NEXT(a_accept_starts_calc, clock, reset, accept, state_ff == ST_CALC)
   `CDID_ASSERT_NOW(a_done_only_in_calc, clock, reset, sum_done, state_ff == ST_CALC)
   `CDID_ASSERT_NEXT(a_leadout_clears, clock, reset, load_rsp && lead_ff, count_ff == '0 && dsum_ff == '0)
   `CDID_ASSERT_NOW(a_count_bounded, clock, reset, 1'b1, count_ff <= COUNT_W'(MAX_TRACKS))

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import cdid_pkg::*;

   localparam int QUIET_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 40;
   localparam int RANDOM_ENTRIES = 600;
   localparam int MAX_PRINTED = 50;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   bit          gaps_on = 1'b1;
   int unsigned entries_sent = 0;
   int unsigned long_tables = 0;
   int unsigned quiet_cycles = 0;

   class disc_id_board;
      rsp_type                 entry_results[$];
      logic [DSUM_TOTAL_W-1:0] digit_total;
      logic [SECS_W-1:0]       first_secs;
      logic [COUNT_W-1:0]      tracks;
      int unsigned             mismatches;
      int unsigned             ids_checked;

      function new();
         digit_total = '0;
         first_secs = '0;
         tracks = '0;
         mismatches = 0;
         ids_checked = 0;
      endfunction

      function logic [5:0] second_digit_sum(logic [SECS_W-1:0] secs);
         int unsigned rest;
         logic [5:0]  acc;
         rest = secs;
         acc = '0;
         while (rest > 0) begin
            acc = acc + 6'(rest % 10);
            rest = rest / 10;
         end
         return acc;
      endfunction

      function void take_entry(req_type e);
         logic [FRAME_W-1:0] frame;
         logic [SECS_W-1:0]  secs;
         logic [SECS_W-1:0]  first;
         logic [ID_W-1:0]    play;
         rsp_type            r;
         frame = e.start_block + FRAME_BIAS;
         secs = SECS_W'(frame / FRAMES_PER_SEC);
         r = '0;
         r.frame_offset = frame;
         if (!e.is_leadout) begin
            // Tracks past the limit still get a frame offset but leave the sums alone.
            if (tracks < DEF_MAX_TRACKS) begin
               if (tracks == 0) begin
                  first_secs = secs;
               end
               digit_total = digit_total + DSUM_TOTAL_W'(second_digit_sum(secs));
               tracks = tracks + 1'b1;
            end
         end else begin
            first = (tracks == 0) ? secs : first_secs;
            play = ID_W'(secs) - ID_W'(first);
            r.disc_id = (ID_W'(digit_total % ID_MODULUS) << 24) | (play << 8)
                        | ID_W'(tracks);
            r.leadout_secs = secs;
            r.id_valid = 1'b1;
            digit_total = '0;
            first_secs = '0;
            tracks = '0;
         end
         entry_results.push_back(r);
      endfunction

      task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
         if (mismatches < MAX_PRINTED) begin
            $display("%0t MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
         end
         mismatches++;
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (entry_results.size() == 0) begin
            report_mismatch("transfer with nothing outstanding", 64'(got.frame_offset), '0);
            return;
         end
         want = entry_results.pop_front();
         if (want.id_valid) begin
            ids_checked++;
         end
         if (got.frame_offset !== want.frame_offset) begin
            report_mismatch("frame_offset", 64'(got.frame_offset), 64'(want.frame_offset));
         end
         if (got.disc_id !== want.disc_id) begin
            report_mismatch("disc_id", 64'(got.disc_id), 64'(want.disc_id));
         end
         if (got.leadout_secs !== want.leadout_secs) begin
            report_mismatch("leadout_secs", 64'(got.leadout_secs),
                            64'(want.leadout_secs));
         end
         if (got.id_valid !== want.id_valid) begin
            report_mismatch("id_valid", 64'(got.id_valid), 64'(want.id_valid));
         end
      endtask
   endclass

   disc_id_board toc_board;

   cd_toc_disc_id_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever begin
         #5 clock = ~clock;
      end
   end

   task automatic send_entry(logic [FRAME_W-1:0] blk, logic lead);
      req_type e;
      e.start_block = blk;
      e.is_leadout = lead;
      while (gaps_on && $urandom_range(0, 99) < 38) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= e;
      do begin
         @(posedge clock);
      end while (!req_ready);
      toc_board.take_entry(e);
      entries_sent++;
   endtask

   task automatic send_table(int unsigned n, logic [FRAME_W-1:0] base, int unsigned step,
                             bit scrambled);
      logic [FRAME_W-1:0] blk;
      blk = base;
      for (int unsigned i = 0; i < n; i++) begin
         send_entry(scrambled ? FRAME_W'($urandom) : blk, 1'b0);
         blk = blk + FRAME_W'($urandom_range(0, step));
      end
      send_entry(scrambled ? FRAME_W'($urandom) : blk, 1'b1);
   endtask

   initial begin
      int unsigned kind;
      int unsigned start_count;
      int unsigned progress;
      logic [FRAME_W-1:0] base;
      toc_board = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // A lead-out with no tracks, at both ends of the address range.
      send_entry(24'd0, 1'b1);
      send_entry(24'hFFFFFF, 1'b1);
      send_entry(24'd0, 1'b0);
      send_entry(24'd16000, 1'b0);
      send_entry(24'd33012, 1'b0);
      send_entry(24'd200000, 1'b1);
      // Largest frame offset, wrapping offset, then a lead-out before the first track.
      send_entry(24'hFFFF69, 1'b0);
      send_entry(24'hFFFFFF, 1'b0);
      send_entry(24'h000000, 1'b1);
      send_entry(24'd1234, 1'b0);
      send_entry(24'hFFFF69, 1'b1);
      send_entry(24'h555555, 1'b0);
      send_entry(24'h5AAAAA, 1'b0);
      send_entry(24'h6F0F0F, 1'b0);
      send_entry(24'h70F0F0, 1'b0);
      send_entry(24'h7FFFFF, 1'b1);
      send_entry(24'hAAAAAA, 1'b1);

      start_count = entries_sent;
      progress = 0;
      while (progress < RANDOM_ENTRIES) begin
         gaps_on = !(progress >= 300 && progress < 420);
         if (long_tables == 0 && progress >= 150) begin
            send_table($urandom_range(100, 106), FRAME_W'($urandom_range(0, 5000)), 3000, 1'b0);
            long_tables++;
         end else begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
               base = ($urandom_range(0, 3) == 0) ? FRAME_W'($urandom)
                                                   : FRAME_W'($urandom_range(0, 20000));
               send_table($urandom_range(1, 20), base, 30000, 1'b0);
            end else if (kind < 82) begin
               send_entry(FRAME_W'($urandom), 1'b1);
            end else begin
               send_table($urandom_range(1, 8), '0, 0, 1'b1);
            end
         end
         progress = entries_sent - start_count;
      end
      req_valid <= 1'b0;
      gaps_on = 1'b1;

      while (toc_board.entry_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d table entries and %0d disc ids, with %0d table(s) over %0d tracks.",
               entries_sent, toc_board.ids_checked, long_tables, DEF_MAX_TRACKS);
      $display("Random idle and stall gaps on both channels; %0d mismatch(es) seen.",
               toc_board.mismatches);
      if (toc_board.mismatches == 0) begin
         $display("cd_toc_disc_id_core regression: pass");
      end else begin
         $display("cd_toc_disc_id_core regression: fail");
      end
      $finish;
   end

   initial begin
      wait (!reset);
      forever begin
         rsp_ready <= !(gaps_on && $urandom_range(0, 99) < 38);
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            toc_board.check_result(rsp_data);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("Timeout: no transfer for %0d cycles.", QUIET_LIMIT);
         $display("cd_toc_disc_id_core regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
